// File: rtl/bitmap_block_allocator_core_assert.svh
// Assertion macros used by the allocator scan engine (bba_back).
// Each expects clk and rst_n in the scope where it is used.
`ifndef BITMAP_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

// cond holds at every edge outside reset
`define BBA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// cons holds in the same cycle as ante
`define BBA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// cons holds in the cycle after ante
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/bba_pkg.sv
// Shared types, codes and helpers for the bitmap block allocator.
// No dependencies.
package bba_pkg;

  localparam int BLOCKS_DEF     = 64;
  localparam int OWNER_BITS_DEF = 8;
  localparam int MAX_RESULTS    = 64;
  localparam int KEPT_W         = 7;
  localparam int QDEPTH         = 2;

  // result status codes
  localparam logic [2:0] ST_ALLOCATED  = 3'd0;
  localparam logic [2:0] ST_NO_SPACE   = 3'd1;
  localparam logic [2:0] ST_RELEASED   = 3'd2;
  localparam logic [2:0] ST_NONE_FOUND = 3'd3;
  localparam logic [2:0] ST_EMPTY      = 3'd4;

  // request kinds decided by the front
  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_EMPTY   = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [6:0] count;
    logic [7:0] owner;
  } cmd_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] block_index;
    logic [2:0] cylinder;
    logic       track;
    logic [1:0] sector;
    logic       last;
  } res_t;

  typedef struct packed {
    logic clearing;
  } bba_stat_t;

  function automatic res_t mk_res(input logic [2:0] status, input logic [5:0] idx,
                                  input logic last);
    res_t r;
    r.status      = status;
    r.block_index = idx;
    r.cylinder    = idx[5:3];
    r.track       = idx[2];
    r.sector      = idx[1:0];
    r.last        = last;
    return r;
  endfunction

endpackage

// File: rtl/bitmap_block_allocator_core.sv
// Channel   Direction  Handshake           Word
// in_*      input      push / full         mode, block_count, owner_id
// out_*     output     empty / pop         status, block_index, geometry, last
//
// A request that allocates or releases blocks is walked by the scan engine, which
// reads one table entry per cycle through the RAM read port unless a full result
// queue stalls the scan in place; an allocation ends after the block that satisfies
// its count. Empty and no-space requests skip the scan. After reset a clearing pass
// writes all BLOCKS table entries; full stays high during it.
//
// Depends on bba_pkg, bba_front, bba_back, bba_resq and bba_ram.
module bitmap_block_allocator_core #(
  parameter int BLOCKS     = bba_pkg::BLOCKS_DEF,
  parameter int OWNER_BITS = bba_pkg::OWNER_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // request side
  input  logic       push,
  output logic       full,
  input  logic       in_mode,
  input  logic [6:0] in_block_count,
  input  logic [7:0] in_owner_id,
  // result side
  output logic       empty,
  input  logic       pop,
  output logic [2:0] out_status,
  output logic [5:0] out_block_index,
  output logic [2:0] out_cylinder,
  output logic       out_track,
  output logic [1:0] out_sector,
  output logic       out_last
);

  // front to back: classified request word
  logic               cmd_vld;
  bba_pkg::cmd_t      cmd;
  logic               cmd_pop;
  bba_pkg::bba_stat_t stat;

  // back to result queue
  logic               res_push;
  bba_pkg::res_t      res_in;
  logic               res_full;
  bba_pkg::res_t      res_out;

  // Front: decode mode and empty counts, queue up to two requests.
  bba_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_mode       (in_mode),
    .in_block_count(in_block_count),
    .in_owner_id   (in_owner_id),
    .stat          (stat),
    .cmd_vld       (cmd_vld),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  // Back: free-count check, first-fit scan, tag match and table update.
  bba_back #(
    .BLOCKS    (BLOCKS),
    .OWNER_BITS(OWNER_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd_vld (cmd_vld),
    .cmd     (cmd),
    .cmd_pop (cmd_pop),
    .stat    (stat),
    .out_push(res_push),
    .out_res (res_in),
    .out_full(res_full)
  );

  // Result buffer: decouple the scan from the consumer.
  bba_resq u_resq (
    .clk     (clk),
    .rst_n   (rst_n),
    .res_push(res_push),
    .res_in  (res_in),
    .res_full(res_full),
    .empty   (empty),
    .pop     (pop),
    .res_out (res_out)
  );

  assign out_status      = res_out.status;
  assign out_block_index = res_out.block_index;
  assign out_cylinder    = res_out.cylinder;
  assign out_track       = res_out.track;
  assign out_sector      = res_out.sector;
  assign out_last        = res_out.last;

endmodule

// File: rtl/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bba_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/bba_front.sv
// Request front: classify incoming words and hold them in a short queue.
// Depends on bba_pkg.
module bba_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic               in_mode,
  input  logic [6:0]         in_block_count,
  input  logic [7:0]         in_owner_id,
  input  bba_pkg::bba_stat_t stat,
  output logic               cmd_vld,
  output bba_pkg::cmd_t      cmd,
  input  logic               cmd_pop
);

  bba_pkg::cmd_t q_r [bba_pkg::QDEPTH];
  logic          wr_r;
  logic          rd_r;
  logic [1:0]    cnt_r;
  logic          do_push;
  logic          do_pop;
  bba_pkg::cmd_t in_cmd;

  always_comb begin
    in_cmd.count = in_block_count;
    in_cmd.owner = in_owner_id;
    if (in_mode) begin
      in_cmd.kind = bba_pkg::KIND_RELEASE;
    end else if (in_block_count == 7'd0) begin
      in_cmd.kind = bba_pkg::KIND_EMPTY;
    end else begin
      in_cmd.kind = bba_pkg::KIND_ALLOC;
    end
  end

  assign full    = stat.clearing || (cnt_r == 2'(bba_pkg::QDEPTH));
  assign do_push = push && !full;
  assign cmd_vld = (cnt_r != 2'd0);
  assign do_pop  = cmd_pop && cmd_vld;
  assign cmd     = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_r] <= in_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wr_r <= ~wr_r;
      end
      if (do_pop) begin
        rd_r <= ~rd_r;
      end
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// File: rtl/bba_back.sv
// Scan engine: clears the block table after reset, then walks it per request.
// Depends on bba_pkg, bba_ram and the assertion macro header.
`include "bitmap_block_allocator_core_assert.svh"

module bba_back #(
  parameter int BLOCKS     = bba_pkg::BLOCKS_DEF,
  parameter int OWNER_BITS = bba_pkg::OWNER_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cmd_vld,
  input  bba_pkg::cmd_t      cmd,
  output logic               cmd_pop,
  output bba_pkg::bba_stat_t stat,
  output logic               out_push,
  output bba_pkg::res_t      out_res,
  input  logic               out_full
);

  localparam int AW = $clog2(BLOCKS);
  localparam int CW = $clog2(BLOCKS + 1);
  localparam int DW = OWNER_BITS + 1;

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]                state_r, state_nxt;
  logic [CW-1:0]             ptr_r, ptr_nxt;
  logic                      s1_vld_r, s1_vld_nxt;
  logic [AW-1:0]             s1_idx_r, s1_idx_nxt;
  logic                      rel_r, rel_nxt;
  logic [6:0]                need_r, need_nxt;
  logic [OWNER_BITS-1:0]     owner_r, owner_nxt;
  logic [bba_pkg::KEPT_W-1:0] kept_r, kept_nxt;
  logic                      pend_vld_r, pend_vld_nxt;
  bba_pkg::res_t             pend_r, pend_nxt;
  logic [2:0]                fin_st_r, fin_st_nxt;
  logic [CW-1:0]             free_r, free_nxt;

  logic                      wr_en;
  logic [AW-1:0]             wr_addr;
  logic [DW-1:0]             wr_data;
  logic                      rd_en;
  logic [DW-1:0]             rd_data;

  logic [OWNER_BITS-1:0]     cmd_own;
  logic                      used;
  logic [OWNER_BITS-1:0]     tag;
  logic                      hit;
  logic                      keep;
  logic                      stall;
  logic                      issue;
  logic                      lack;
  logic [5:0]                idx6;

  bba_ram #(
    .WIDTH(DW),
    .DEPTH(BLOCKS)
  ) u_tbl (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(ptr_r[AW-1:0]),
    .rd_data(rd_data)
  );

  assign cmd_own       = OWNER_BITS'(cmd.owner);
  assign used          = rd_data[DW-1];
  assign tag           = rd_data[OWNER_BITS-1:0];
  assign idx6          = 6'(s1_idx_r);
  assign stat.clearing = (state_r == S_CLR);
  assign lack          = ({{CW{1'b0}}, cmd.count} > {7'd0, free_r});

  // a hit is a block this request acts on; only the first MAX_RESULTS are reported
  assign hit   = (state_r == S_SCAN) && s1_vld_r &&
                 (rel_r ? (used && (tag == owner_r)) : (!used && (need_r != 7'd0)));
  assign keep  = hit && (kept_r < bba_pkg::KEPT_W'(bba_pkg::MAX_RESULTS));
  assign stall = keep && pend_vld_r && out_full;

  always_comb begin
    state_nxt    = state_r;
    ptr_nxt      = ptr_r;
    s1_vld_nxt   = s1_vld_r;
    s1_idx_nxt   = s1_idx_r;
    rel_nxt      = rel_r;
    need_nxt     = need_r;
    owner_nxt    = owner_r;
    kept_nxt     = kept_r;
    pend_vld_nxt = pend_vld_r;
    pend_nxt     = pend_r;
    fin_st_nxt   = fin_st_r;
    free_nxt     = free_r;
    cmd_pop      = 1'b0;
    out_push     = 1'b0;
    out_res      = pend_r;
    wr_en        = 1'b0;
    wr_addr      = s1_idx_r;
    wr_data      = '0;
    rd_en        = 1'b0;
    issue        = 1'b0;

    case (state_r)
      S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = ptr_r[AW-1:0];
        if (ptr_r == CW'(BLOCKS - 1)) begin
          ptr_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          ptr_nxt = ptr_r + CW'(1);
        end
      end

      S_IDLE: begin
        if (cmd_vld) begin
          cmd_pop      = 1'b1;
          rel_nxt      = (cmd.kind == bba_pkg::KIND_RELEASE);
          need_nxt     = cmd.count;
          owner_nxt    = cmd_own;
          ptr_nxt      = '0;
          s1_vld_nxt   = 1'b0;
          kept_nxt     = '0;
          pend_vld_nxt = 1'b0;
          case (cmd.kind)
            bba_pkg::KIND_RELEASE: begin
              fin_st_nxt = bba_pkg::ST_NONE_FOUND;
              state_nxt  = S_SCAN;
            end
            bba_pkg::KIND_ALLOC: begin
              if (lack) begin
                fin_st_nxt = bba_pkg::ST_NO_SPACE;
                state_nxt  = S_FIN;
              end else begin
                fin_st_nxt = bba_pkg::ST_ALLOCATED;
                state_nxt  = S_SCAN;
              end
            end
            default: begin
              fin_st_nxt = bba_pkg::ST_EMPTY;
              state_nxt  = S_FIN;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (!stall) begin
          if (hit) begin
            wr_en = 1'b1;
            if (rel_r) begin
              wr_data  = '0;
              free_nxt = free_r + CW'(1);
            end else begin
              wr_data  = {1'b1, owner_r};
              free_nxt = free_r - CW'(1);
              need_nxt = need_r - 7'd1;
            end
          end
          // hold the newest report back so the final one can carry last
          if (keep) begin
            if (pend_vld_r) begin
              out_push = 1'b1;
            end
            pend_nxt     = bba_pkg::mk_res(rel_r ? bba_pkg::ST_RELEASED
                                                 : bba_pkg::ST_ALLOCATED, idx6, 1'b0);
            pend_vld_nxt = 1'b1;
            kept_nxt     = kept_r + bba_pkg::KEPT_W'(1);
          end
          issue = (ptr_r != CW'(BLOCKS)) && (rel_r || (need_nxt != 7'd0));
          if (issue) begin
            rd_en      = 1'b1;
            s1_vld_nxt = 1'b1;
            s1_idx_nxt = ptr_r[AW-1:0];
            ptr_nxt    = ptr_r + CW'(1);
          end else begin
            s1_vld_nxt = 1'b0;
            state_nxt  = S_FIN;
          end
        end
      end

      S_FIN: begin
        out_push = 1'b1;
        if (pend_vld_r) begin
          out_res      = pend_r;
          out_res.last = 1'b1;
        end else begin
          out_res = bba_pkg::mk_res(fin_st_r, 6'd0, 1'b1);
        end
        if (!out_full) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLR;
      ptr_r      <= '0;
      s1_vld_r   <= 1'b0;
      pend_vld_r <= 1'b0;
      kept_r     <= '0;
      free_r     <= CW'(BLOCKS);
    end else begin
      state_r    <= state_nxt;
      ptr_r      <= ptr_nxt;
      s1_vld_r   <= s1_vld_nxt;
      pend_vld_r <= pend_vld_nxt;
      kept_r     <= kept_nxt;
      free_r     <= free_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx_r <= s1_idx_nxt;
    rel_r    <= rel_nxt;
    need_r   <= need_nxt;
    owner_r  <= owner_nxt;
    pend_r   <= pend_nxt;
    fin_st_r <= fin_st_nxt;
  end

  `BBA_ASSERT_ALWAYS(a_free_bound, free_r <= CW'(BLOCKS), "free count above block count")
  `BBA_ASSERT_ALWAYS(a_kept_bound, kept_r <= bba_pkg::KEPT_W'(bba_pkg::MAX_RESULTS),
    "report count above limit")
  `BBA_ASSERT_IMPL(a_scan_not_last, (state_r == S_SCAN) && out_push, !out_res.last,
    "last word sent before scan end")
  `BBA_ASSERT_NEXT(a_fin_retire, (state_r == S_FIN) && !out_full, state_r == S_IDLE,
    "final word taken but request not retired")
  `BBA_ASSERT_IMPL(a_clr_no_pop, state_r == S_CLR, !cmd_pop && !out_push,
    "request activity during clearing pass")

endmodule

// File: rtl/bba_resq.sv
// Result queue: two-entry buffer between the scan engine and the result port.
// Depends on bba_pkg.
module bba_resq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          res_push,
  input  bba_pkg::res_t res_in,
  output logic          res_full,
  output logic          empty,
  input  logic          pop,
  output bba_pkg::res_t res_out
);

  bba_pkg::res_t q_r [bba_pkg::QDEPTH];
  logic          wr_r;
  logic          rd_r;
  logic [1:0]    cnt_r;
  logic          do_push;
  logic          do_pop;

  assign res_full = (cnt_r == 2'(bba_pkg::QDEPTH));
  assign empty    = (cnt_r == 2'd0);
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;
  assign res_out  = q_r[rd_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_r] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= 1'b0;
      rd_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) begin
        wr_r <= ~wr_r;
      end
      if (do_pop) begin
        rd_r <= ~rd_r;
      end
      cnt_r <= cnt_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule
